// ===== rtl/cms_pkg.sv =====
// cms_pkg: shared widths, reset values, register indexes and pipeline depths
// for the coordinated move setup block. No dependencies.
`default_nettype none

package cms_pkg;

    // axis counts
    localparam int AXIS_COUNT_DEF = 4;
    localparam int FIELD_AXES     = 4;
    localparam int LEN_AXES       = 3;

    // field widths
    localparam int CNT_W   = 32;
    localparam int SPM_W   = 32;
    localparam int RATIO_W = 17;
    localparam int LEN_W   = 32;
    localparam int SQ_W    = 64;
    localparam int DOM_W   = 2;

    localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;
    localparam logic [LEN_W-1:0]   LEN_MAX   = 32'hFFFF_FFFF;

    // steps per mm reset values, Q16.16
    localparam logic [SPM_W-1:0] SPM_X_RST = 32'd5242880;
    localparam logic [SPM_W-1:0] SPM_Y_RST = 32'd5242880;
    localparam logic [SPM_W-1:0] SPM_Z_RST = 32'd83886080;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_X_SPM = 2'd0,
        CFG_Y_SPM = 2'd1,
        CFG_Z_SPM = 2'd2
    } t_cfg_reg;

    // pipeline depths, counted in register stages after the request edge
    localparam int RATIO_QW   = 17;
    localparam int PART_QW    = 32;
    localparam int SQRT_STEPS = 32;
    localparam int LAT_MAX    = 2;
    localparam int LAT_SQ     = 1 + PART_QW + 1;
    localparam int LAT_SUM    = LAT_SQ + 2;
    localparam int LAT_ROOT   = LAT_SUM + SQRT_STEPS;
    localparam int LAT_OUT    = LAT_ROOT + 1;
    localparam int RATIO_PAD  = LAT_SQ - LAT_MAX - RATIO_QW;

    // what one lane hands to the merging stage
    typedef struct packed {
        logic [RATIO_W-1:0] ratio;
        logic [SQ_W-1:0]    sq;
        logic               sat;
    } t_lane_res;

endpackage

`default_nettype wire

// ===== rtl/cms_div_pipe.sv =====
// cms_div_pipe: pipelined restoring divider, one quotient bit per stage.
// Needs a quotient below 2**QW. Depends on nothing.
`default_nettype none

module cms_div_pipe #(
    parameter int DW = 32,
    parameter int QW = 17
) (
    input  wire logic             i_clk,
    input  wire logic [DW+QW-1:0] i_num,
    input  wire logic [DW-1:0]    i_den,
    output logic      [QW-1:0]    o_quo
);

    localparam int CW = DW + QW;

    logic [CW-1:0] r_rem [QW-1];
    logic [DW-1:0] r_den [QW-1];
    logic [QW-1:0] r_quo [QW];

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int SH = QW - 1 - s;
        logic [CW-1:0] w_rem_in;
        logic [DW-1:0] w_den_in;
        logic [QW-1:0] w_quo_in;
        logic [CW-1:0] w_sub;
        logic          w_ge;

        if (s == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_den_in = r_den[s-1];
            assign w_quo_in = r_quo[s-1];
        end

        // trial subtract of the shifted divisor
        assign w_sub = {{QW{1'b0}}, w_den_in} << SH;
        assign w_ge  = (w_rem_in >= w_sub);

        always_ff @(posedge i_clk) begin
            r_quo[s] <= w_ge ? (w_quo_in | (QW'(1) << SH)) : w_quo_in;
        end

        if (s < QW - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[s] <= w_ge ? (w_rem_in - w_sub) : w_rem_in;
                r_den[s] <= w_den_in;
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

`default_nettype wire

// ===== rtl/cms_sqrt_pipe.sv =====
// cms_sqrt_pipe: pipelined integer square root, floor, one root bit per stage.
// Depends on nothing.
`default_nettype none

module cms_sqrt_pipe #(
    parameter int IW = 64
) (
    input  wire logic            i_clk,
    input  wire logic [IW-1:0]   i_val,
    output logic      [IW/2-1:0] o_root
);

    localparam int STEPS = IW / 2;
    localparam int RW    = IW + 1;

    logic [IW-1:0] r_rem  [STEPS-1];
    logic [RW-1:0] r_root [STEPS];

    for (genvar s = 0; s < STEPS; s++) begin : g_stage
        localparam logic [RW-1:0] BIT = RW'(1) << (2 * (STEPS - 1 - s));
        logic [IW-1:0] w_rem_in;
        logic [RW-1:0] w_root_in;
        logic [RW-1:0] w_trial;
        logic          w_ge;

        if (s == 0) begin : g_first
            assign w_rem_in  = i_val;
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rem_in  = r_rem[s-1];
            assign w_root_in = r_root[s-1];
        end

        // try to take root + bit out of the remainder
        assign w_trial = w_root_in + BIT;
        assign w_ge    = ({1'b0, w_rem_in} >= w_trial);

        always_ff @(posedge i_clk) begin
            r_root[s] <= w_ge ? ((w_root_in >> 1) + BIT) : (w_root_in >> 1);
        end

        if (s < STEPS - 1) begin : g_carry
            logic [RW-1:0] w_diff;
            assign w_diff = {1'b0, w_rem_in} - w_trial;
            always_ff @(posedge i_clk) begin
                r_rem[s] <= w_ge ? w_diff[IW-1:0] : w_rem_in;
            end
        end
    end

    assign o_root = r_root[STEPS-1][IW/2-1:0];

endmodule

`default_nettype wire

// ===== rtl/cms_lane.sv =====
// cms_lane: one axis lane: speed ratio division, and for length axes the
// millimetre division and its square. Depends on cms_pkg, cms_div_pipe.
`default_nettype none

module cms_lane
    import cms_pkg::*;
#(
    parameter bit LEN_EN = 1'b1
) (
    input  wire logic             i_clk,
    input  wire logic [CNT_W-1:0] i_mag,
    input  wire logic [CNT_W-1:0] i_max,
    input  wire logic [SPM_W-1:0] i_spm,
    output t_lane_res             o_res
);

    logic [CNT_W-1:0]          r_mag2;
    logic                      r_rzero [RATIO_QW];
    logic [RATIO_W-1:0]        r_rpad  [RATIO_PAD];
    logic [CNT_W+RATIO_QW-1:0] w_rnum;
    logic [RATIO_QW-1:0]       w_rquo;
    logic [RATIO_W-1:0]        w_ratio;

    // hold the magnitude one stage so it meets the largest count
    always_ff @(posedge i_clk) begin
        r_mag2 <= i_mag;
    end

    // rounded ratio: (mag * 65536 + max / 2) / max
    assign w_rnum = {1'b0, r_mag2, 16'h0000} + {18'h0, i_max[CNT_W-1:1]};

    cms_div_pipe #(.DW(CNT_W), .QW(RATIO_QW)) u_rdiv (
        .i_clk (i_clk),
        .i_num (w_rnum),
        .i_den (i_max),
        .o_quo (w_rquo)
    );

    // track the all-zero move alongside the divider
    always_ff @(posedge i_clk) begin
        r_rzero[0] <= (i_max == '0);
        for (int k = 1; k < RATIO_QW; k++) begin
            r_rzero[k] <= r_rzero[k-1];
        end
    end

    assign w_ratio = r_rzero[RATIO_QW-1] ? '0 : w_rquo;

    // align the ratio with the squared length part
    always_ff @(posedge i_clk) begin
        r_rpad[0] <= w_ratio;
        for (int k = 1; k < RATIO_PAD; k++) begin
            r_rpad[k] <= r_rpad[k-1];
        end
    end

    assign o_res.ratio = r_rpad[RATIO_PAD-1];

    if (LEN_EN) begin : g_len
        logic [CNT_W+PART_QW-1:0] w_pnum;
        logic [PART_QW-1:0]       w_pquo;
        logic [PART_QW-1:0]       w_part;
        logic                     r_pzero [PART_QW];
        logic                     r_psat  [PART_QW];
        logic [SQ_W-1:0]          r_sq;
        logic                     r_sat;

        // part in mm: (mag * 2**32 + spm / 2) / spm
        assign w_pnum = {i_mag, 1'b0, i_spm[SPM_W-1:1]};

        cms_div_pipe #(.DW(SPM_W), .QW(PART_QW)) u_pdiv (
            .i_clk (i_clk),
            .i_num (w_pnum),
            .i_den (i_spm),
            .o_quo (w_pquo)
        );

        // the part reaches 2**32 exactly when mag >= spm
        always_ff @(posedge i_clk) begin
            r_pzero[0] <= (i_spm == '0);
            r_psat[0]  <= (i_spm != '0) && (i_mag >= i_spm);
            for (int k = 1; k < PART_QW; k++) begin
                r_pzero[k] <= r_pzero[k-1];
                r_psat[k]  <= r_psat[k-1];
            end
        end

        assign w_part = r_pzero[PART_QW-1] ? '0 : w_pquo;

        // square the part
        always_ff @(posedge i_clk) begin
            r_sq  <= SQ_W'(w_part) * SQ_W'(w_part);
            r_sat <= r_psat[PART_QW-1];
        end

        assign o_res.sq  = r_sq;
        assign o_res.sat = r_sat;
    end else begin : g_nolen
        assign o_res.sq  = '0;
        assign o_res.sat = 1'b0;
    end

endmodule

`default_nettype wire

// ===== rtl/coordinated_move_setup.sv =====
// coordinated_move_setup: top level. Magnitudes, dominant axis, axis lanes,
// sum of squares, root and result register. Depends on cms_pkg, cms_lane,
// cms_sqrt_pipe.
//
//  channel   ports                                          handshake
//  --------  ---------------------------------------------  ---------------------
//  move in   i_x/y/z/a_step_count                           start & !busy
//  result    o_lead_axis, o_x/y/z/a_ratio,                  o_valid, one cycle
//            o_path_length_mm
//  config    i_cfg_idx, i_cfg_data                          i_cfg_we, no wait
//
// One request per clock while busy is low; results leave in request order.
// The longest path runs through the 32-stage millimetre divider and the 32-stage root.
// busy is high only during reset and the cycle after it.
// Reset clears the strobe pipeline and loads the steps-per-mm defaults.
// The receiver cannot stall; results leave on the strobe.
`default_nettype none

module coordinated_move_setup
    import cms_pkg::*;
#(
    parameter int AXIS_COUNT = AXIS_COUNT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [CNT_W-1:0] i_x_step_count,
    input  wire logic signed [CNT_W-1:0] i_y_step_count,
    input  wire logic signed [CNT_W-1:0] i_z_step_count,
    input  wire logic signed [CNT_W-1:0] i_a_step_count,
    input  wire logic               i_cfg_we,
    input  wire logic [1:0]         i_cfg_idx,
    input  wire logic [SPM_W-1:0]   i_cfg_data,
    output logic                    o_valid,
    output logic [DOM_W-1:0]        o_lead_axis,
    output logic [RATIO_W-1:0]      o_x_ratio,
    output logic [RATIO_W-1:0]      o_y_ratio,
    output logic [RATIO_W-1:0]      o_z_ratio,
    output logic [RATIO_W-1:0]      o_a_ratio,
    output logic [LEN_W-1:0]        o_path_length_mm
);

    localparam int DOM_D = LAT_ROOT - LAT_MAX;
    localparam int RAT_D = LAT_ROOT - LAT_SQ;

    logic                   r_busy;
    logic                   w_acc;
    logic [SPM_W-1:0]       r_spm   [LEN_AXES];
    logic [SPM_W-1:0]       w_lspm  [FIELD_AXES];
    logic [CNT_W-1:0]       w_cnt   [FIELD_AXES];
    logic [CNT_W-1:0]       r_mag   [FIELD_AXES];
    logic [CNT_W-1:0]       w_max;
    logic [DOM_W-1:0]       w_dom;
    logic [CNT_W-1:0]       r_max;
    logic [DOM_W-1:0]       r_dom;
    t_lane_res              w_res   [FIELD_AXES];
    logic [LAT_OUT-1:0]     r_vld;
    logic [DOM_W-1:0]       r_dpipe [DOM_D];
    logic [RATIO_W-1:0]     r_rpipe [RAT_D][FIELD_AXES];
    logic [SQ_W:0]          r_s01;
    logic [SQ_W-1:0]        r_sq2;
    logic                   r_sat35;
    logic [SQ_W+1:0]        w_sum;
    logic [SQ_W-1:0]        r_sum;
    logic                   r_sat;
    logic                   r_spipe [SQRT_STEPS];
    logic [LEN_W-1:0]       w_root;
    logic [RATIO_W-1:0]     w_dom_ratio;

    // hold busy through reset and the cycle after it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy  = r_busy;
    assign w_acc = start & ~r_busy;

    // configuration writes; unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spm[0] <= SPM_X_RST;
            r_spm[1] <= SPM_Y_RST;
            r_spm[2] <= SPM_Z_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_X_SPM: r_spm[0] <= i_cfg_data;
                CFG_Y_SPM: r_spm[1] <= i_cfg_data;
                CFG_Z_SPM: r_spm[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cnt[0] = i_x_step_count;
    assign w_cnt[1] = i_y_step_count;
    assign w_cnt[2] = i_z_step_count;
    assign w_cnt[3] = i_a_step_count;

    // magnitudes; axes beyond the axis count read as zero
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < FIELD_AXES; i++) begin
            if (i < AXIS_COUNT) begin
                r_mag[i] <= w_cnt[i][CNT_W-1] ? (-w_cnt[i]) : w_cnt[i];
            end else begin
                r_mag[i] <= '0;
            end
        end
    end

    // first largest magnitude wins
    always_comb begin
        w_max = '0;
        w_dom = '0;
        for (int i = 0; i < FIELD_AXES; i++) begin
            if (r_mag[i] > w_max) begin
                w_max = r_mag[i];
                w_dom = DOM_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_max <= w_max;
        r_dom <= w_dom;
    end

    // axis lanes
    for (genvar i = 0; i < FIELD_AXES; i++) begin : g_lane
        if (i < LEN_AXES) begin : g_spm
            assign w_lspm[i] = r_spm[i];
        end else begin : g_nospm
            assign w_lspm[i] = '0;
        end

        cms_lane #(.LEN_EN(i < LEN_AXES)) u_lane (
            .i_clk (i_clk),
            .i_mag (r_mag[i]),
            .i_max (r_max),
            .i_spm (w_lspm[i]),
            .o_res (w_res[i])
        );
    end

    // sum of squares in two adds; any carry out saturates
    always_ff @(posedge i_clk) begin
        r_s01   <= {1'b0, w_res[0].sq} + {1'b0, w_res[1].sq};
        r_sq2   <= w_res[2].sq;
        r_sat35 <= w_res[0].sat | w_res[1].sat | w_res[2].sat;
    end

    assign w_sum = {1'b0, r_s01} + {2'b00, r_sq2};

    always_ff @(posedge i_clk) begin
        r_sum <= w_sum[SQ_W-1:0];
        r_sat <= r_sat35 | (w_sum[SQ_W+1:SQ_W] != 2'b00);
    end

    cms_sqrt_pipe #(.IW(SQ_W)) u_sqrt (
        .i_clk  (i_clk),
        .i_val  (r_sum),
        .o_root (w_root)
    );

    // advance the request strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT_OUT-2:0], w_acc};
        end
    end

    // carry dominant axis, ratios and saturation alongside the root
    always_ff @(posedge i_clk) begin
        r_dpipe[0] <= r_dom;
        for (int k = 1; k < DOM_D; k++) begin
            r_dpipe[k] <= r_dpipe[k-1];
        end
        for (int i = 0; i < FIELD_AXES; i++) begin
            r_rpipe[0][i] <= w_res[i].ratio;
            for (int k = 1; k < RAT_D; k++) begin
                r_rpipe[k][i] <= r_rpipe[k-1][i];
            end
        end
        r_spipe[0] <= r_sat;
        for (int k = 1; k < SQRT_STEPS; k++) begin
            r_spipe[k] <= r_spipe[k-1];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        o_lead_axis      <= r_dpipe[DOM_D-1];
        o_x_ratio        <= r_rpipe[RAT_D-1][0];
        o_y_ratio        <= r_rpipe[RAT_D-1][1];
        o_z_ratio        <= r_rpipe[RAT_D-1][2];
        o_a_ratio        <= r_rpipe[RAT_D-1][3];
        o_path_length_mm <= r_spipe[SQRT_STEPS-1] ? LEN_MAX : w_root;
    end

    assign o_valid = r_vld[LAT_OUT-1];

    always_comb begin
        case (o_lead_axis)
            2'd0:    w_dom_ratio = o_x_ratio;
            2'd1:    w_dom_ratio = o_y_ratio;
            2'd2:    w_dom_ratio = o_z_ratio;
            default: w_dom_ratio = o_a_ratio;
        endcase
    end

    // dominant axis runs at full speed unless the move is empty
    a_dom_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (w_dom_ratio == RATIO_ONE) ||
                    ((o_lead_axis == 2'd0) && (o_x_ratio == '0) &&
                     (o_y_ratio == '0) && (o_z_ratio == '0) && (o_a_ratio == '0)))
        else $error("dominant axis ratio is not one on a non-empty move");

    // no ratio exceeds one
    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_x_ratio <= RATIO_ONE) && (o_y_ratio <= RATIO_ONE) &&
                    (o_z_ratio <= RATIO_ONE) && (o_a_ratio <= RATIO_ONE))
        else $error("ratio above one");

endmodule

`default_nettype wire

// ===== tb/coordinated_move_setup_tb.sv =====
// coordinated_move_setup_tb: checks dominant axis, speed ratios and XYZ path length
// against an in-bench predictor, across several steps-per-mm settings.
// Depends on cms_pkg and the coordinated_move_setup RTL.
`timescale 1ns / 100ps

module coordinated_move_setup_tb;
    import cms_pkg::*;

    // index that maps to no register; writes to it must be dropped
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam int         DRAIN_CYCLES = LAT_OUT + 20;

    typedef struct {
        logic [DOM_W-1:0]   dom;
        logic [RATIO_W-1:0] ratio [FIELD_AXES];
        logic [LEN_W-1:0]   len;
    } t_move_setup;

    // scoreboard: predicts move setups and compares them in order
    class move_setup_board;
        t_move_setup     pending_q [$];
        logic [SPM_W-1:0] spm [LEN_AXES];
        int              errors;

        function new();
            spm[0] = SPM_X_RST;
            spm[1] = SPM_Y_RST;
            spm[2] = SPM_Z_RST;
            errors = 0;
        endfunction

        function void set_spm(logic [1:0] idx, logic [SPM_W-1:0] val);
            if (idx == CFG_X_SPM || idx == CFG_Y_SPM || idx == CFG_Z_SPM) begin
                spm[idx] = val;
            end
        endfunction

        function automatic logic [63:0] root_floor(logic [63:0] v);
            logic [63:0] rem, root, bitv;
            rem  = v;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > rem) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (rem >= root + bitv) begin
                    rem  = rem - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            return root;
        endfunction

        // note an accepted request and queue its expected setup
        function void note(logic signed [CNT_W-1:0] cnt [FIELD_AXES]);
            t_move_setup e;
            logic [63:0] mag [FIELD_AXES];
            logic [63:0] peak, part;
            logic [64:0] sum;
            logic        sat;
            peak = 0;
            e.dom = 0;
            for (int i = 0; i < FIELD_AXES; i++) begin
                mag[i] = {32'd0, cnt[i][31] ? (~cnt[i] + 32'd1) : cnt[i]};
                if (mag[i] > peak) begin
                    peak  = mag[i];
                    e.dom = i[DOM_W-1:0];
                end
            end
            for (int i = 0; i < FIELD_AXES; i++) begin
                e.ratio[i] = (peak == 0) ? '0 :
                    RATIO_W'((mag[i] * 64'd65536 + (peak >> 1)) / peak);
            end
            sum = 0;
            sat = 1'b0;
            for (int i = 0; i < LEN_AXES; i++) begin
                part = (spm[i] == 0) ? 64'd0 :
                    ((mag[i] << 32) + {33'd0, spm[i][31:1]}) / {32'd0, spm[i]};
                if (part > 64'hFFFF_FFFF) sat = 1'b1;
                if (!sat) begin
                    sum = sum + {1'b0, part * part};
                    if (sum[64]) sat = 1'b1;
                end
            end
            e.len = sat ? LEN_MAX : LEN_W'(root_floor(sum[63:0]));
            pending_q.push_back(e);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
            errors++;
        endtask

        // compare one result with the oldest expectation
        task check(t_move_setup r);
            t_move_setup e;
            if (pending_q.size() == 0) begin
                report("unexpected result", r.len, 0);
            end else begin
                e = pending_q.pop_front();
                if (r.dom !== e.dom) report("lead_axis", r.dom, e.dom);
                for (int i = 0; i < FIELD_AXES; i++) begin
                    if (r.ratio[i] !== e.ratio[i]) report($sformatf("ratio[%0d]", i),
                        r.ratio[i], e.ratio[i]);
                end
                if (r.len !== e.len) report("path_length_mm", r.len, e.len);
            end
        endtask
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [CNT_W-1:0] i_x_step_count, i_y_step_count;
    logic signed [CNT_W-1:0] i_z_step_count, i_a_step_count;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_idx;
    logic [SPM_W-1:0]   i_cfg_data;
    logic               o_valid;
    logic [DOM_W-1:0]   o_lead_axis;
    logic [RATIO_W-1:0] o_x_ratio, o_y_ratio, o_z_ratio, o_a_ratio;
    logic [LEN_W-1:0]   o_path_length_mm;

    move_setup_board board;
    bit              idle_on;

    coordinated_move_setup u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_x_step_count(i_x_step_count), .i_y_step_count(i_y_step_count),
        .i_z_step_count(i_z_step_count), .i_a_step_count(i_a_step_count),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_lead_axis(o_lead_axis),
        .o_x_ratio(o_x_ratio), .o_y_ratio(o_y_ratio), .o_z_ratio(o_z_ratio),
        .o_a_ratio(o_a_ratio), .o_path_length_mm(o_path_length_mm)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // observe accepted requests and results at each edge
    always @(posedge i_clk) begin
        logic signed [CNT_W-1:0] cnt [FIELD_AXES];
        t_move_setup r;
        if (i_rst_n && start && !busy) begin
            cnt[0] = i_x_step_count;
            cnt[1] = i_y_step_count;
            cnt[2] = i_z_step_count;
            cnt[3] = i_a_step_count;
            board.note(cnt);
        end
        if (i_rst_n && o_valid) begin
            r.dom      = o_lead_axis;
            r.ratio[0] = o_x_ratio;
            r.ratio[1] = o_y_ratio;
            r.ratio[2] = o_z_ratio;
            r.ratio[3] = o_a_ratio;
            r.len      = o_path_length_mm;
            board.check(r);
        end
    end

    // hold start low for a random burst, sometimes
    task maybe_idle();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // present one move and wait until it is taken
    task send_move(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] a);
        maybe_idle();
        start          <= 1'b1;
        i_x_step_count <= x;
        i_y_step_count <= y;
        i_z_step_count <= z;
        i_a_step_count <= a;
        do @(posedge i_clk); while (busy);
    endtask

    task drain();
        start <= 1'b0;
        while (board.pending_q.size() != 0) @(posedge i_clk);
    endtask

    task write_cfg(logic [1:0] idx, logic [SPM_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        board.set_spm(idx, val);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [31:0] rand_count(int mode);
        case (mode)
            0: return $urandom;
            1: return $urandom_range(0, 2000) - 1000;
            2: return 32'h8000_0000 + $urandom_range(0, 3);
            3: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            default: return 32'(int'($urandom_range(0, 200000)) - 100000);
        endcase
    endfunction

    task random_moves(int n);
        logic [31:0] c [FIELD_AXES];
        int          m;
        for (int k = 0; k < n; k++) begin
            m = $urandom_range(0, 9);
            for (int i = 0; i < FIELD_AXES; i++) begin
                c[i] = rand_count(m < 4 ? 0 : (m < 6 ? 4 : (m == 6 ? 1 :
                       $urandom_range(0, 4))));
            end
            // force ties now and then
            if (m == 9) c[$urandom_range(0, 3)] = c[$urandom_range(0, 3)];
            if (m == 8) c[$urandom_range(0, 3)] = -c[$urandom_range(0, 3)];
            send_move(c[0], c[1], c[2], c[3]);
        end
    endtask

    task directed_moves();
        send_move(0, 0, 0, 0);
        send_move(32'h7FFF_FFFF, 0, 0, 0);
        send_move(0, 32'h8000_0001, 0, 0);
        send_move(0, 0, 32'h8000_0000, 0);
        send_move(0, 0, 0, 32'h7FFF_FFFF);
        send_move(5, -5, 5, -5);
        send_move(1, 3, -3, 2);
        send_move(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_move(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0001);
        send_move(-1, 1, 0, 2);
        send_move(3, 2, 1, 0);
        send_move(1, 0, 0, 3);
        send_move(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF);
        send_move(800, -800, 1280, 7);
    endtask

    initial begin
        logic [SPM_W-1:0] presets [6][LEN_AXES];
        board          = new();
        idle_on        = 1'b1;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_X_SPM;
        i_cfg_data     = '0;
        i_x_step_count = '0;
        i_y_step_count = '0;
        i_z_step_count = '0;
        i_a_step_count = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults
        directed_moves();
        random_moves(50);
        drain();

        presets[0] = '{32'd0, 32'd0, 32'd0};
        presets[1] = '{32'd1, 32'd1, 32'd1};
        presets[2] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
        presets[3] = '{32'd65536, 32'd0, 32'h0001_8000};
        presets[4] = '{$urandom, $urandom, $urandom};
        presets[5] = '{$urandom_range(1, 32'h00FF_FFFF), $urandom_range(1, 32'h0FFF_FFFF),
                       $urandom};
        for (int p = 0; p < 6; p++) begin
            write_cfg(CFG_X_SPM, presets[p][0]);
            write_cfg(CFG_Y_SPM, presets[p][1]);
            write_cfg(CFG_Z_SPM, presets[p][2]);
            write_cfg(CFG_UNUSED, $urandom);
            if (p == 5) idle_on = 1'b0;
            if (p == 2 || p == 3) directed_moves();
            random_moves(55);
            drain();
        end

        // wait out the pipeline, then conclude
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.errors == 0 && board.pending_q.size() == 0) begin
            $display("coordinated_move_setup_tb passed");
        end else begin
            $display("coordinated_move_setup_tb failed");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("coordinated_move_setup_tb failed");
        $finish;
    end

endmodule

// ===== coordinated_move_setup.f =====
rtl/cms_pkg.sv
rtl/cms_div_pipe.sv
rtl/cms_sqrt_pipe.sv
rtl/cms_lane.sv
rtl/coordinated_move_setup.sv
tb/coordinated_move_setup_tb.sv
